/* hw/rtl/dlh_pkg.sv */
package dlh_pkg;

    localparam int unsigned CNT_W = 8;

    localparam logic [CNT_W-1:0] THRESHOLD_RST  = 8'd5;
    localparam logic [CNT_W-1:0] HOLD_TICKS_RST = 8'd50;
    localparam logic [CNT_W-1:0] CNT_MAX        = 8'hFF;
    localparam logic [CNT_W-1:0] CNT_ZERO       = 8'h00;

    // register indexes on the configuration port
    localparam logic CFG_THRESHOLD  = 1'b0;
    localparam logic CFG_HOLD_TICKS = 1'b1;

    typedef logic [1:0] t_category;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_DETECT = 2'd1,
        EV_EXPIRE = 2'd2
    } t_event;

    typedef struct packed {
        logic             latch_flag;
        logic [CNT_W-1:0] hit_counter;
        logic [CNT_W-1:0] hold_counter;
        t_category        latched_class;
    } t_state;

endpackage

/* hw/rtl/dlh_step.sv */
module dlh_step
    import dlh_pkg::*;
(
    input  t_state           i_state,
    input  t_category        i_category,
    input  logic [CNT_W-1:0] i_threshold,
    input  logic [CNT_W-1:0] i_hold_ticks,
    output t_state           o_state,
    output t_event           o_event
);

    logic [CNT_W-1:0] hit_up;
    logic [CNT_W-1:0] hit_dn;
    logic [CNT_W-1:0] hold_dn;

    assign hit_up  = (i_state.hit_counter == CNT_MAX) ? CNT_MAX
                                                     : i_state.hit_counter + 8'd1;
    assign hit_dn  = (i_state.hit_counter == CNT_ZERO) ? CNT_ZERO
                                                      : i_state.hit_counter - 8'd1;
    assign hold_dn = i_state.hold_counter - 8'd1;

    always_comb begin
        o_state = i_state;
        o_event = EV_NONE;
        if (i_state.latch_flag) begin
            if (i_state.hold_counter == CNT_ZERO) begin
                // release phase
                if (i_category != i_state.latched_class) begin
                    if (hit_up >= i_threshold) begin
                        o_state.latch_flag  = 1'b0;
                        o_state.hit_counter = CNT_ZERO;
                    end else begin
                        o_state.hit_counter = hit_up;
                    end
                end else begin
                    o_state.hit_counter = hit_dn;
                end
            end else begin
                o_state.hold_counter = hold_dn;
                if (hold_dn == CNT_ZERO) begin
                    o_event = EV_EXPIRE;
                end
            end
        end else begin
            // keyword classes are 2 and 3
            if (i_category[1]) begin
                if (hit_up >= i_threshold) begin
                    o_state.latch_flag    = 1'b1;
                    o_state.latched_class = i_category;
                    o_state.hold_counter  = i_hold_ticks;
                    o_state.hit_counter   = CNT_ZERO;
                    o_event               = EV_DETECT;
                end else begin
                    o_state.hit_counter = hit_up;
                end
            end else begin
                o_state.hit_counter = hit_dn;
            end
        end
    end

endmodule

/* hw/rtl/detection_latch_with_hold_unit.sv */
// the result is registered and is valid in the cycle after its input transfer
// throughput: one category per cycle, sustained while the result side keeps up
// the output register refills in the cycle it is taken, so stalls cost no bubble
// reset (synchronous, active low) clears the latch, both counters, the held class
// and the output valid; threshold returns to 5 and hold_ticks to 50
module detection_latch_with_hold_unit
    import dlh_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [1:0] category
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [1:0] event_res, [2] latched, [4:3] held_class
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_data
);

    t_state           r_state;
    t_state           n_state;
    t_event           n_event;
    logic [CNT_W-1:0] r_threshold;
    logic [CNT_W-1:0] r_hold_ticks;
    logic             r_out_valid;
    t_event           r_out_event;
    logic             r_out_latched;
    t_category        r_out_class;
    logic             in_xfer;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign in_xfer    = i_s_tvalid && o_s_tready;

    dlh_step u_step (
        .i_state      (r_state),
        .i_category   (i_s_tdata[1:0]),
        .i_threshold  (r_threshold),
        .i_hold_ticks (r_hold_ticks),
        .o_state      (n_state),
        .o_event      (n_event)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= '0;
            r_threshold  <= THRESHOLD_RST;
            r_hold_ticks <= HOLD_TICKS_RST;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_THRESHOLD:  r_threshold  <= i_cfg_data;
                    CFG_HOLD_TICKS: r_hold_ticks <= i_cfg_data;
                    default:        r_threshold  <= r_threshold;
                endcase
            end
            if (in_xfer) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out_event   <= n_event;
            r_out_latched <= n_state.latch_flag;
            r_out_class   <= n_state.latched_class;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out_class, r_out_latched, r_out_event};

`ifndef SYNTHESIS
    a_hold_only_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.hold_counter != CNT_ZERO) |-> r_state.latch_flag)
        else $error("hold timer running while not latched");

    a_detect_latches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_event == EV_DETECT) |-> r_out_latched)
        else $error("detection reported without latch");

    a_expire_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_event == EV_EXPIRE) |-> r_out_latched)
        else $error("expiry reported while not latched");

    a_xfer_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_out_valid)
        else $error("input transfer produced no result");

    a_state_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_xfer |=> $stable(r_state))
        else $error("state changed without an input transfer");
`endif

endmodule
